// File: hdl/pfs_pkg.sv
// Shared types and constants for the priority FIFO task scheduler.
package pfs_pkg;

  localparam int TASK_W     = 4;
  localparam int TASK_SLOTS = 16;
  localparam int PRIO_W     = 8;

  typedef logic [TASK_W-1:0] task_id_t;
  typedef logic [PRIO_W-1:0] prio_t;

  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_t;

endpackage

// File: hdl/pfs_prio_enc.sv
// Priority encoder that finds the most urgent non-empty level.
module pfs_prio_enc #(
  parameter int NUM_LEVELS = 8
) (
  input  logic [NUM_LEVELS-1:0]                             nonempty,
  output logic                                              found,
  output logic [((NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1)-1:0] level
);

  localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // The highest set bit wins, so the scan runs upward and later hits override.
  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i]) begin
        found = 1'b1;
        level = LVL_W'(i);
      end
    end
  end

endmodule

// File: hdl/priority_fifo_task_scheduler.sv
// Top level of the fixed-priority multilevel FIFO task scheduler.
// Throughput: one request per cycle, enqueue or schedule, unless a schedule waits for room.
// A request is captured in the input register at acceptance and processed from there;
// a schedule waits there until the output register is free, then writes its result.
// The per-request path is one priority encode plus one head/link/tail update.
// Reset (synchronous, active low) empties every level, clears idle_task and both valid flags.
module priority_fifo_task_scheduler #(
  parameter int NUM_LEVELS = 8,
  parameter int MAX_TASKS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [0:0]             in_op,
  input  logic [3:0]             in_task_id,
  input  logic [7:0]             in_priority_req,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_next_task,
  output logic                   out_was_idle,
  // Configuration: the idle task register.
  input  logic                   cfg_wr_en,
  input  logic [3:0]             cfg_wr_data
);

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SLOT_W = $clog2(pfs_pkg::TASK_SLOTS);

  // Input register. It holds one request until the processing step can take it.
  logic               in_valid_r;
  pfs_pkg::op_t       in_op_r;
  pfs_pkg::task_id_t  in_task_r;
  pfs_pkg::prio_t     in_prio_r;

  // Result register. Since it is only written by a schedule, it also holds
  // the running task, that is the last task chosen.
  logic               out_valid_r;
  pfs_pkg::task_id_t  out_task_r;
  logic               out_idle_r;

  logic [pfs_pkg::TASK_W-1:0] idle_task_r;

  // Per-level list state. Head, tail and link entries are meaningful only
  // while the owning level is non-empty, so they carry no reset.
  pfs_pkg::task_id_t  head_r  [NUM_LEVELS];
  pfs_pkg::task_id_t  tail_r  [NUM_LEVELS];
  logic [CNT_W-1:0]   count_r [NUM_LEVELS];
  pfs_pkg::task_id_t  link_r  [pfs_pkg::TASK_SLOTS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic                  sched_found;
  logic [LVL_W-1:0]      sched_lvl;
  logic [LVL_W-1:0]      enq_lvl;
  logic                  is_sched;
  logic                  advance;
  logic                  enq_fire;
  logic                  sched_fire;
  logic                  out_free;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
  end

  pfs_prio_enc #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_prio_enc (
    .nonempty (nonempty),
    .found    (sched_found),
    .level    (sched_lvl)
  );

  // Priorities at or beyond the top level are clamped to the most urgent one.
  assign enq_lvl = (32'(in_prio_r) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                   : LVL_W'(in_prio_r);

  // An enqueue always retires; a schedule needs room in the result register,
  // which is free when empty or when its result leaves in this cycle.
  assign is_sched   = (in_op_r == pfs_pkg::OP_SCHEDULE);
  assign out_free   = !out_valid_r || out_ready;
  assign advance    = in_valid_r && (!is_sched || out_free);
  assign enq_fire   = advance && !is_sched;
  assign sched_fire = advance && is_sched;
  assign in_ready   = !in_valid_r || advance;

  assign out_valid     = out_valid_r;
  assign out_next_task = out_task_r;
  assign out_was_idle  = out_idle_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idle_task_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (sched_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        idle_task_r <= cfg_wr_data;
      end
    end
  end

  // Input payload capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r   <= pfs_pkg::op_t'(in_op);
      in_task_r <= in_task_id;
      in_prio_r <= in_priority_req;
    end
  end

  // Level occupancy counters. An enqueue to a full level is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count_r[i] <= '0;
      end
    end else if (enq_fire) begin
      if (count_r[enq_lvl] != CNT_W'(MAX_TASKS)) begin
        count_r[enq_lvl] <= count_r[enq_lvl] + CNT_W'(1);
      end
    end else if (sched_fire && sched_found) begin
      count_r[sched_lvl] <= count_r[sched_lvl] - CNT_W'(1);
    end
  end

  // List pointers and the shared link table, plus the result payload.
  always_ff @(posedge clk) begin
    if (enq_fire && (count_r[enq_lvl] != CNT_W'(MAX_TASKS))) begin
      if (count_r[enq_lvl] == '0) begin
        head_r[enq_lvl] <= in_task_r;
      end else begin
        link_r[tail_r[enq_lvl][SLOT_W-1:0]] <= in_task_r;
      end
      tail_r[enq_lvl] <= in_task_r;
    end
    if (sched_fire) begin
      if (sched_found) begin
        out_task_r <= head_r[sched_lvl];
        out_idle_r <= 1'b0;
        // Advance the head unless this removal empties the level.
        if (count_r[sched_lvl] != CNT_W'(1)) begin
          head_r[sched_lvl] <= link_r[head_r[sched_lvl][SLOT_W-1:0]];
        end
      end else begin
        out_task_r <= idle_task_r;
        out_idle_r <= 1'b1;
      end
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the priority FIFO task scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS  = 8;
  localparam int MAX_TASKS   = 16;
  // The cycle budget is far above the slowest correct run.
  localparam int CYCLE_LIMIT = 1000000;
  // Cycles allowed for a request in flight to settle inside the block.
  localparam int SETTLE_CYCLES = 4;

  // One scheduling decision, as it appears on the result channel.
  typedef struct packed {
    pfs_pkg::task_id_t next_task;
    logic              was_idle;
  } pick_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pfs_pkg::op_t      in_op = pfs_pkg::OP_ENQUEUE;
  pfs_pkg::task_id_t in_task_id = '0;
  pfs_pkg::prio_t    in_priority_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pfs_pkg::task_id_t out_next_task;
  logic              out_was_idle;
  logic              cfg_wr_en = 1'b0;
  pfs_pkg::task_id_t cfg_wr_data = '0;

  priority_fifo_task_scheduler #(
    .NUM_LEVELS(NUM_LEVELS),
    .MAX_TASKS (MAX_TASKS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_task_id     (in_task_id),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_task  (out_next_task),
    .out_was_idle   (out_was_idle),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our own copy of the scheduler state. Each level is a linked list threaded
  // through a link table that is indexed by task identifier, exactly as the
  // block keeps it, so that duplicate tasks corrupt the lists the same way.
  pfs_pkg::task_id_t link_tbl [pfs_pkg::TASK_SLOTS];
  pfs_pkg::task_id_t lvl_head [NUM_LEVELS];
  pfs_pkg::task_id_t lvl_tail [NUM_LEVELS];
  int                lvl_count[NUM_LEVELS];
  pfs_pkg::task_id_t idle_task_cfg;

  // Decisions that the block still owes us, oldest first.
  pick_t expected_picks[$];

  int mismatches = 0;
  int cycle_count = 0;

  // Apply one accepted request to the queue state. A schedule request
  // pushes the decision the block has to return.
  function automatic void update_level_queues(pfs_pkg::op_t op, pfs_pkg::task_id_t tid,
                                              pfs_pkg::prio_t prio);
    int    lvl;
    pick_t pick;
    if (op == pfs_pkg::OP_ENQUEUE) begin
      // Any priority beyond the last level lands in the most urgent one.
      lvl = (int'(prio) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(prio);
      // A full level silently drops the request.
      if (lvl_count[lvl] < MAX_TASKS) begin
        if (lvl_count[lvl] == 0) begin
          lvl_head[lvl] = tid;
        end else begin
          link_tbl[lvl_tail[lvl]] = tid;
        end
        lvl_tail[lvl] = tid;
        lvl_count[lvl]++;
      end
    end else begin
      // With every level empty the background task is returned.
      pick.next_task = idle_task_cfg;
      pick.was_idle  = 1'b1;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
        if (lvl_count[l] != 0) begin
          pick.next_task = lvl_head[l];
          pick.was_idle  = 1'b0;
          lvl_count[l]--;
          if (lvl_count[l] != 0) begin
            lvl_head[l] = link_tbl[pick.next_task];
          end
          break;
        end
      end
      expected_picks.push_back(pick);
    end
  endfunction

  // Present one request and hold it until the block takes it. The valid
  // stays high on return so that back-to-back requests leave no bubble.
  task automatic send_request(pfs_pkg::op_t op, pfs_pkg::task_id_t tid,
                              pfs_pkg::prio_t prio);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_task_id      <= tid;
    in_priority_req <= prio;
    do @(posedge clk); while (!in_ready);
    update_level_queues(op, tid, prio);
  endtask

  // Drop valid for a number of cycles between bursts.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed decision has come back. An
  // enqueue returns nothing, so a further settle wait lets the last one settle.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the idle task register. Only called while the block is idle.
  task automatic write_idle_task(pfs_pkg::task_id_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    idle_task_cfg = value;
  endtask

  // Right after reset every level is empty, so a schedule must return the
  // reset value of the idle task. Then the register is moved to its top value.
  task automatic test_idle_pick();
    send_request(pfs_pkg::OP_SCHEDULE, 4'hA, 8'h00);
    wait_until_drained();
    write_idle_task(4'hF);
    send_request(pfs_pkg::OP_SCHEDULE, 4'h5, 8'hFF);
    wait_until_drained();
  endtask

  // Fill the lowest level with every task identifier, which also writes the
  // link entries of tasks 0 to 14, then push one more that must be dropped.
  task automatic test_full_level();
    for (int t = 0; t < pfs_pkg::TASK_SLOTS; t++) begin
      send_request(pfs_pkg::OP_ENQUEUE, pfs_pkg::task_id_t'(t), 8'h00);
    end
    send_request(pfs_pkg::OP_ENQUEUE, 4'h7, 8'h00);
    wait_until_drained();
  endtask

  // Priorities at the top level and beyond it all land in the top level and
  // keep their arrival order. Task 15, enqueued a second time and then followed
  // by task 5, gets the last link entry written, so no later pop can follow a link that was never set.
  task automatic test_priority_clamp();
    send_request(pfs_pkg::OP_ENQUEUE, 4'hF, 8'hFF);
    send_request(pfs_pkg::OP_ENQUEUE, 4'h5, 8'(NUM_LEVELS));
    send_request(pfs_pkg::OP_ENQUEUE, 4'h9, 8'(NUM_LEVELS - 1));
    // Three picks from the top level, then three from the bottom one.
    repeat (6) send_request(pfs_pkg::OP_SCHEDULE, 4'h0, 8'h00);
    wait_until_drained();
  endtask

  // One phase of random traffic. The share of schedule requests steers the
  // levels toward empty (idle picks) or toward full (dropped enqueues); a
  // focused phase piles every enqueue onto a single priority.
  task automatic random_phase(int requests, int sched_pct, bit focused);
    int             burst_left;
    pfs_pkg::op_t   op;
    pfs_pkg::prio_t prio;
    pfs_pkg::prio_t focus_prio;
    burst_left = 0;
    focus_prio = pfs_pkg::prio_t'($urandom_range(0, NUM_LEVELS - 1));
    for (int n = 0; n < requests; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // Roughly one burst in four follows the previous one with no gap.
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      op = ($urandom_range(0, 99) < sched_pct) ? pfs_pkg::OP_SCHEDULE : pfs_pkg::OP_ENQUEUE;
      if (focused) begin
        prio = focus_prio;
      end else if ($urandom_range(0, 9) < 7) begin
        prio = pfs_pkg::prio_t'($urandom_range(0, NUM_LEVELS - 1));
      end else begin
        prio = pfs_pkg::prio_t'($urandom_range(0, 255));
      end
      send_request(op, pfs_pkg::task_id_t'($urandom_range(0, 15)), prio);
      burst_left--;
    end
  endtask

  // Several phases, each under its own idle task setting, the extremes
  // among them. The register is only written once the block has gone quiet.
  task automatic test_random_traffic();
    write_idle_task(4'h0);
    random_phase(100, 40, 1'b0);
    wait_until_drained();
    write_idle_task(pfs_pkg::task_id_t'($urandom_range(1, 14)));
    random_phase(90, 20, 1'b1);
    wait_until_drained();
    write_idle_task(4'hF);
    random_phase(110, 75, 1'b0);
    wait_until_drained();
    write_idle_task(pfs_pkg::task_id_t'($urandom_range(0, 15)));
    random_phase(120, 50, 1'b0);
    wait_until_drained();
    write_idle_task(pfs_pkg::task_id_t'($urandom_range(0, 15)));
    random_phase(110, 60, 1'b0);
    wait_until_drained();
  endtask

  // The receiver switches now and then between always ready, a repeating
  // 16-bit stall pattern and heavy random back-pressure.
  logic [15:0] stall_pattern = '0;
  int          stall_mode = 0;
  int          stall_age = 0;

  always @(posedge clk) begin
    if (stall_age == 0) begin
      stall_mode    <= $urandom_range(0, 2);
      stall_pattern <= 16'($urandom);
      stall_age     <= $urandom_range(20, 120);
    end else begin
      stall_age <= stall_age - 1;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= stall_pattern[cycle_count[3:0]];
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Every decision taken off the result channel is compared with the oldest
  // one still owed.
  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected decision: next_task %0d was_idle %0b",
                   out_next_task, out_was_idle);
        end
      end else begin
        want = expected_picks.pop_front();
        if (out_next_task !== want.next_task || out_was_idle !== want.was_idle) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("decision mismatch: next_task exp %0d got %0d, was_idle exp %0b got %0b",
                     want.next_task, out_next_task, want.was_idle, out_was_idle);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("priority_fifo_task_scheduler verification failed");
      $finish;
    end
  end

  initial begin
    // The model starts where the block does after reset: no level holds a
    // task and the idle task is zero.
    for (int i = 0; i < pfs_pkg::TASK_SLOTS; i++) link_tbl[i] = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i]  = '0;
      lvl_tail[i]  = '0;
      lvl_count[i] = 0;
    end
    idle_task_cfg = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_pick();
    test_full_level();
    test_priority_clamp();
    test_random_traffic();

    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("priority_fifo_task_scheduler verification clean");
    end else begin
      $display("priority_fifo_task_scheduler verification failed");
    end
    $finish;
  end

endmodule
